// ===== src/sacs_pkg.sv =====
// shared constants, codes and state type for the sorted array ceiling search
package sacs_pkg;

  // element store geometry
  localparam int DEPTH  = 1024;
  localparam int ADDR_W = 10;
  localparam int LEN_W  = 11;
  localparam int DATA_W = 32;

  // value returned when no ceiling exists
  localparam logic signed [DATA_W-1:0] NO_CEILING = -32'sd1;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // search sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

endpackage

// ===== src/sorted_array_ceiling_search_core.sv =====
// Ceiling search over a sorted element store, one probe of the store per clock cycle.
// A write request is dropped when its index is at or beyond the effective length
// (array_length, saturated to 1024). A query request is accepted, then the binary
// search probes the store, then the result register is loaded; the search ends early
// on an exact hit, and an empty store skips the search. The probe rate is set by the
// store's single registered read port, which the compare-and-narrow loop uses once per
// cycle. The block takes one request at a time; a finished result waits in the output
// register, and the block takes the next request once that result is loaded there.
// Elements are assumed sorted non-decreasing; entries probed must have been written
// since reset.
module sorted_array_ceiling_search_core
  import sacs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_write_en,
  input  logic [LEN_W-1:0]         cfg_write_data,
  // request channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     operation,
  input  logic [ADDR_W-1:0]        element_index,
  input  logic signed [DATA_W-1:0] item_value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] ceiling_value,
  output logic                     found
);

  state_t state, state_next;

  logic [LEN_W-1:0]         array_length;
  logic [LEN_W-1:0]         eff_len;
  logic [LEN_W-1:0]         lo, lo_next;
  logic [LEN_W-1:0]         hi_ex, hi_ex_next;
  logic signed [DATA_W-1:0] query_value;
  logic signed [DATA_W-1:0] best, best_next;
  logic                     have, have_next;

  logic                     in_fire;
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] probe;
  logic                     hit;
  logic                     above;
  logic                     search_done;
  logic [LEN_W:0]           first_sum;
  logic [LEN_W:0]           next_sum;
  logic [ADDR_W-1:0]        first_mid;
  logic [ADDR_W-1:0]        next_mid;
  logic [ADDR_W-1:0]        probe_addr;
  logic                     load_out;

  // length register; the effective length is saturated to the store depth
  always_ff @(posedge clk) begin
    if (rst) begin
      array_length <= '0;
    end else if (cfg_write_en) begin
      array_length <= cfg_write_data;
    end
  end

  assign eff_len = (array_length > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : array_length;

  // element store
  sacs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (element_index),
    .wdata (item_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared compare unit and window narrowing
  always_comb begin
    probe       = signed'(ram_rdata);
    hit         = (probe == query_value);
    above       = (probe > query_value);
    lo_next     = lo;
    hi_ex_next  = hi_ex;
    best_next   = best;
    have_next   = have;
    if (hit || above) begin
      best_next = probe;
      have_next = 1'b1;
    end
    if (above) begin
      hi_ex_next = LEN_W'(probe_addr);
    end else if (!hit) begin
      lo_next = LEN_W'(probe_addr) + LEN_W'(1);
    end
    search_done = hit || (lo_next >= hi_ex_next);
    next_sum    = (LEN_W+1)'(lo_next) + (LEN_W+1)'(hi_ex_next) - (LEN_W+1)'(1);
    next_mid    = next_sum[ADDR_W:1];
    first_sum   = (LEN_W+1)'(eff_len) - (LEN_W+1)'(1);
    first_mid   = first_sum[ADDR_W:1];
  end

  // probe address register tracks the address under read
  always_ff @(posedge clk) begin
    probe_addr <= ram_raddr;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && operation == OP_QUERY) begin
          state_next = (eff_len == '0) ? ST_FINISH : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (search_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    load_out  = 1'b0;
    ram_raddr = next_mid;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = first_mid;
      end
      ST_SEARCH: begin
        ram_raddr = next_mid;
      end
      ST_FINISH: begin
        load_out = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    in_fire = in_valid && in_ready;
    ram_we  = in_fire && (operation == OP_WRITE) && (LEN_W'(element_index) < eff_len);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // search window and running best
  always_ff @(posedge clk) begin
    if (in_fire && operation == OP_QUERY) begin
      lo          <= '0;
      hi_ex       <= eff_len;
      query_value <= item_value;
      best        <= NO_CEILING;
      have        <= 1'b0;
    end else if (state == ST_SEARCH) begin
      lo    <= lo_next;
      hi_ex <= hi_ex_next;
      best  <= best_next;
      have  <= have_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ceiling_value <= best;
      found         <= have;
    end
  end

  // checks
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (ceiling_value == NO_CEILING))
    else $error("no-ceiling result carries a value other than -1");

  a_window_open: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (lo < hi_ex && hi_ex <= eff_len))
    else $error("search window empty or beyond length while searching");

  a_window_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH && state_next == ST_SEARCH)
      |=> (LEN_W'(hi_ex - lo) < $past(LEN_W'(hi_ex - lo))))
    else $error("search window failed to shrink");

  a_no_load_over_pending: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !load_out)
    else $error("result loaded over a pending result");

endmodule

// ===== src/sacs_ram.sv =====
// generic simple dual-port ram with registered read
module sacs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
